/* design/xsr_pkg.sv */
// Shared constants, codes and handshake structs of the xorshift64 bounded random block.
package xsr_pkg;

  localparam int STATE_W  = 64;
  localparam int SPAN_W   = 32;
  localparam int ADC_BITS = 12;
  localparam int KIND_W   = 2;
  localparam int CNT_W    = $clog2(STATE_W);

  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 7;
  localparam int SHIFT_C = 17;

  localparam logic [KIND_W-1:0] KIND_SEED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UNS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SGN  = 2'd2;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

/* design/xsr_if.sv */
// Valid/ready channel interfaces for draw requests and draw results.
interface xsr_in_if
  import xsr_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [ADC_BITS-1:0]      adc_sample;
  logic [STATE_W-1:0]       bound;
  logic signed [SPAN_W-1:0] min_value;
  logic signed [SPAN_W-1:0] max_value;

  modport source (output valid, kind, adc_sample, bound, min_value, max_value, input ready);
  modport sink   (input valid, kind, adc_sample, bound, min_value, max_value, output ready);
endinterface

interface xsr_out_if
  import xsr_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STATE_W-1:0]       unsigned_value;
  logic signed [SPAN_W-1:0] signed_value;
  logic                     range_error;

  modport source (output valid, unsigned_value, signed_value, range_error, input ready);
  modport sink   (input valid, unsigned_value, signed_value, range_error, output ready);
endinterface

/* design/xsr_gen.sv */
// Generator state register with seed shift-in and xorshift advance.
module xsr_gen
  import xsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               seed_en,
  input  logic               seed_bit,
  input  logic               adv_en,
  output logic [STATE_W-1:0] adv_value
);

  logic [STATE_W-1:0] state_r, state_nxt;
  logic [STATE_W-1:0] t1, t2;

  // Three xor-shift layers; only wiring and one xor per layer.
  always_comb begin
    t1        = state_r ^ (state_r << SHIFT_A);
    t2        = t1 ^ (t1 >> SHIFT_B);
    adv_value = t2 ^ (t2 << SHIFT_C);
  end

  always_comb begin
    state_nxt = state_r;
    if (seed_en) begin
      state_nxt = {state_r[STATE_W-2:0], seed_bit};
    end else if (adv_en) begin
      state_nxt = adv_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/xsr_div.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module xsr_div
  import xsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  div_ctl_t           ctl,
  input  logic [STATE_W-1:0] dividend,
  input  logic [STATE_W-1:0] divisor,
  output div_sts_t           sts,
  output logic [STATE_W-1:0] remainder
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [STATE_W-1:0] dvd_r, dvd_nxt;
  logic [STATE_W-1:0] dsr_r, dsr_nxt;
  logic [STATE_W-1:0] rem_r, rem_nxt;
  logic [STATE_W:0]   shifted;
  logic [STATE_W+1:0] diff;

  always_comb begin
    shifted = {rem_r, dvd_r[STATE_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '1;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[STATE_W-2:0], 1'b0};
      // No borrow means the divisor fits, and the difference is below it.
      if (!diff[STATE_W+1]) begin
        rem_nxt = diff[STATE_W-1:0];
      end else begin
        rem_nxt = shifted[STATE_W-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign remainder = rem_r;

endmodule

/* design/xorshift64_bounded_random_top.sv */
// Top level of the xorshift64 bounded random generator.
//
// in_if carries requests: a seed beat shifts adc_sample bit 0 into the
// 64-bit generator state and gives no result; an unsigned draw advances the
// state and returns state modulo bound; a signed draw returns min_value plus
// state modulo (max_value - min_value). A zero bound or an empty signed range
// still advances the state, returns 0 or min_value and sets range_error.
// Kind 3 is accepted and ignored. out_if carries one result beat per draw.
// A draw runs from acceptance through the bit-serial remainder unit, hands
// its finish to the controller and then loads its result into the output
// register. Erroneous draws skip the remainder unit and go straight on to
// the load. One item is in flight at a time, so no request is accepted while
// a draw is under way; the next one is accepted in the cycle after the
// result is loaded.
// The output register lets the next request be accepted while a result waits;
// if out_if stalls, a finished draw waits until the register frees up.
// Synchronous reset clears the generator state to zero; an all-zero state
// stays zero until a seed beat brings in a one.
module xorshift64_bounded_random_top
  import xsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  xsr_in_if.sink    in_if,
  xsr_out_if.source out_if
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_t;

  state_t                   state_r, state_nxt;
  logic                     sgn_r, sgn_nxt;
  logic                     err_r, err_nxt;
  logic signed [SPAN_W-1:0] min_r, min_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [STATE_W-1:0]       out_uns_r, out_uns_nxt;
  logic signed [SPAN_W-1:0] out_sgn_r, out_sgn_nxt;
  logic                     out_err_r, out_err_nxt;

  logic               accept;
  logic               seed_en, adv_en;
  logic [STATE_W-1:0] adv_value;
  logic [STATE_W-1:0] divisor;
  logic [SPAN_W:0]    span;
  logic [STATE_W-1:0] remainder;
  logic               out_free;
  div_ctl_t           div_ctl;
  div_sts_t           div_sts;

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  // Span at 33 bits never wraps; a positive span fits in 32 bits.
  assign span = {in_if.max_value[SPAN_W-1], in_if.max_value}
              - {in_if.min_value[SPAN_W-1], in_if.min_value};

  xsr_gen u_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed_en   (seed_en),
    .seed_bit  (in_if.adc_sample[0]),
    .adv_en    (adv_en),
    .adv_value (adv_value)
  );

  xsr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (adv_value),
    .divisor   (divisor),
    .sts       (div_sts),
    .remainder (remainder)
  );

  always_comb begin
    state_nxt     = state_r;
    sgn_nxt       = sgn_r;
    err_nxt       = err_r;
    min_nxt       = min_r;
    seed_en       = 1'b0;
    adv_en        = 1'b0;
    div_ctl.start = 1'b0;
    divisor       = in_if.bound;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_uns_nxt   = out_uns_r;
    out_sgn_nxt   = out_sgn_r;
    out_err_nxt   = out_err_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          min_nxt = in_if.min_value;
          case (in_if.kind)
            KIND_SEED: begin
              seed_en = 1'b1;
            end
            KIND_UNS: begin
              adv_en  = 1'b1;
              sgn_nxt = 1'b0;
              err_nxt = (in_if.bound == '0);
              divisor = in_if.bound;
              div_ctl.start = (in_if.bound != '0);
              state_nxt = (in_if.bound == '0) ? S_DONE : S_DIV;
            end
            KIND_SGN: begin
              adv_en  = 1'b1;
              sgn_nxt = 1'b1;
              err_nxt = span[SPAN_W] || (span == '0);
              divisor = {{(STATE_W-SPAN_W){1'b0}}, span[SPAN_W-1:0]};
              div_ctl.start = !(span[SPAN_W] || (span == '0));
              state_nxt = (span[SPAN_W] || (span == '0)) ? S_DONE : S_DIV;
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_err_nxt   = err_r;
          out_uns_nxt   = (sgn_r || err_r) ? '0 : remainder;
          if (!sgn_r) begin
            out_sgn_nxt = '0;
          end else if (err_r) begin
            out_sgn_nxt = min_r;
          end else begin
            out_sgn_nxt = min_r + $signed(remainder[SPAN_W-1:0]);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sgn_r     <= sgn_nxt;
    err_r     <= err_nxt;
    min_r     <= min_nxt;
    out_uns_r <= out_uns_nxt;
    out_sgn_r <= out_sgn_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.unsigned_value = out_uns_r;
  assign out_if.signed_value   = out_sgn_r;
  assign out_if.range_error    = out_err_r;

  // The remainder unit is never restarted in the middle of a division.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("remainder unit started while busy");

  // While waiting on a division, the unit is working or has just finished.
  a_div_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_sts.busy || div_sts.done))
    else $error("waiting on an idle remainder unit");

  // A division finishes only while the controller waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIV))
    else $error("division finished outside the wait state");

  // A started division is in the unit on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |=> div_sts.busy && (state_r == S_DIV))
    else $error("division start lost");

endmodule
